@@ rtl/drr_pkg.sv @@
// Shared types, constants and helpers for the DMA request ring scheduler.
// Used by drr_slot_ram, drr_sequencer and dma_request_ring_scheduler.
// No dependencies.
package drr_pkg;

  // Ring size and field widths.
  localparam int SLOT_COUNT_DEF = 64;
  localparam int BUDGET_W       = 24;
  localparam int LINE_W         = 8;
  localparam int SIZE_W         = 16;
  localparam int ADDR_W         = 32;
  localparam int SLOT_NUM_W     = 6;

  // Register reset values.
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 24'd40960;
  localparam logic [LINE_W-1:0]   LINE_RESET   = 8'd224;

  // Request codes carried by req_type.
  typedef enum logic [2:0] {
    REQ_COPY    = 3'd0,
    REQ_FILL    = 3'd1,
    REQ_PROCESS = 3'd2,
    REQ_WAIT    = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_t;

  // Result codes carried by result_kind.
  typedef enum logic [2:0] {
    KIND_GRANT     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_PENDING   = 3'd2,
    KIND_DONE      = 3'd3,
    KIND_DESC      = 3'd4,
    KIND_PASS_IDLE = 3'd5,
    KIND_CLEARED   = 3'd6
  } kind_t;

  // Descriptor modes.
  typedef enum logic [1:0] {
    MODE_COPY16 = 2'd0,
    MODE_COPY32 = 2'd1,
    MODE_FILL16 = 2'd2,
    MODE_FILL32 = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_BYTE_BUDGET = 1'b0,
    CFG_LAST_LINE   = 1'b1
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_WALK,
    ST_DECIDE,
    ST_REPLY
  } seq_state_t;

  // One input beat.
  typedef struct packed {
    logic [2:0]            req_type;
    logic [ADDR_W-1:0]     src_addr;
    logic [ADDR_W-1:0]     dest_addr;
    logic [SIZE_W-1:0]     byte_count;
    logic                  wide_units;
    logic [31:0]           fill_word;
    logic                  query_all;
    logic [SLOT_NUM_W-1:0] query_index;
    logic [LINE_W-1:0]     line_count;
  } item_t;

  // Configuration register values.
  typedef struct packed {
    logic [BUDGET_W-1:0] budget;
    logic [LINE_W-1:0]   last_line;
  } cfg_t;

  // One stored slot. The data word holds the source of a copy or the
  // already masked pattern of a fill.
  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [SIZE_W-1:0] size;
    logic [1:0]        mode;
    logic [31:0]       data;
  } entry_t;

  // One output beat.
  typedef struct packed {
    logic [2:0]            kind;
    logic [SLOT_NUM_W-1:0] slot;
    logic [1:0]            mode;
    logic [ADDR_W-1:0]     src;
    logic [ADDR_W-1:0]     dest;
    logic [SIZE_W-1:0]     size;
    logic [31:0]           value;
    logic                  last;
  } result_t;

  // A final, non-descriptor result with every payload field zero.
  function automatic result_t make_reply(input logic [2:0] kind,
                                         input logic [SLOT_NUM_W-1:0] slot);
    result_t r;
    r      = '0;
    r.kind = kind;
    r.slot = slot;
    r.last = 1'b1;
    return r;
  endfunction

endpackage

@@ rtl/dma_request_ring_scheduler.sv @@
// Top level of the DMA request ring scheduler: ports, configuration
// registers and the output register. Depends on drr_pkg, drr_slot_ram and
// drr_sequencer.
//
//   Channel  Handshake                Beat
//   in       in_valid / in_stall      req_type, addresses, size, fill, query, line
//   out      out_valid / out_stall    result_kind, slot_number, desc_*, last_of_run
//   cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item at a time: in_stall rises after an accepted beat and falls once the last
// result sits in the output register. An enqueue tests one slot per cycle; a process
// pass walks the drained slots, one slot memory read per step; wait and clear go
// straight to their reply.
// Reset is synchronous, keeps in_stall high and empties the ring at once through
// per-slot busy flags; a stalled output holds the sequencer in place.
module dma_request_ring_scheduler #(
  parameter int SLOT_COUNT = drr_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [31:0] src_addr,
  input  logic [31:0] dest_addr,
  input  logic [15:0] byte_count,
  input  logic        wide_units,
  input  logic [31:0] fill_word,
  input  logic        query_all,
  input  logic [5:0]  query_index,
  input  logic [7:0]  line_count,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [5:0]  slot_number,
  output logic [1:0]  desc_mode,
  output logic [31:0] desc_src,
  output logic [31:0] desc_dest,
  output logic [15:0] desc_size,
  output logic [31:0] desc_value,
  output logic        last_of_run,
  // Configuration channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);
  import drr_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);

  cfg_t              cfg;
  item_t             item;
  logic              idle;
  logic              start;
  logic              out_free;
  logic              push;
  result_t           push_data;
  result_t           out_q;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  entry_t            rd_data;

  // Input beat; nothing is taken while reset is applied.
  assign in_stall = rst || !idle;
  assign start    = in_valid && !in_stall;
  always_comb begin
    item.req_type    = req_type;
    item.src_addr    = src_addr;
    item.dest_addr   = dest_addr;
    item.byte_count  = byte_count;
    item.wide_units  = wide_units;
    item.fill_word   = fill_word;
    item.query_all   = query_all;
    item.query_index = query_index;
    item.line_count  = line_count;
  end

  // Configuration registers.
  assign cfg_ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.budget    <= BUDGET_RESET;
      cfg.last_line <= LINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BYTE_BUDGET: cfg.budget    <= cfg_data;
        CFG_LAST_LINE:   cfg.last_line <= cfg_data[LINE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Output register.
  assign out_free = !out_valid || !out_stall;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_q <= push_data;
    end
  end

  assign result_kind = out_q.kind;
  assign slot_number = out_q.slot;
  assign desc_mode   = out_q.mode;
  assign desc_src    = out_q.src;
  assign desc_dest   = out_q.dest;
  assign desc_size   = out_q.size;
  assign desc_value  = out_q.value;
  assign last_of_run = out_q.last;

  drr_sequencer #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg       (cfg),
    .idle      (idle),
    .out_free  (out_free),
    .push      (push),
    .push_data (push_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  drr_slot_ram #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

`ifndef SYNTHESIS
  // Any request that produces a result makes the block go busy.
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (req_type <= REQ_CLEAR)) |=> in_stall)
    else $error("block took a request and did not go busy");

  // Only descriptors may be followed by more results of the same item.
  a_reply_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind != KIND_DESC)) |-> last_of_run)
    else $error("non-descriptor result not marked final");

  // A drained slot always carries a transfer.
  a_desc_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_DESC)) |-> (desc_size != '0))
    else $error("descriptor emitted for an empty slot");

  // Copy descriptors never carry a fill pattern.
  a_copy_no_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_DESC) &&
     ((desc_mode == MODE_COPY16) || (desc_mode == MODE_COPY32))) |-> (desc_value == '0))
    else $error("copy descriptor carries a fill pattern");
`endif

endmodule

@@ rtl/drr_slot_ram.sv @@
// Slot storage of the DMA request ring: one write port, one registered read.
// Depends on drr_pkg for the slot entry type.
module drr_slot_ram #(
  parameter int SLOT_COUNT = drr_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  input  drr_pkg::entry_t               wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  output drr_pkg::entry_t               rd_data
);
  import drr_pkg::*;

  entry_t mem [SLOT_COUNT];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/drr_sequencer.sv @@
// Sequencer of the DMA request ring: slot search, drain walk with the
// byte-total adder and budget compare, wait queries and clear.
// Depends on drr_pkg; drives the ports of drr_slot_ram.
module drr_sequencer #(
  parameter int SLOT_COUNT = drr_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  drr_pkg::item_t                item,
  input  drr_pkg::cfg_t                 cfg,
  output logic                          idle,
  input  logic                          out_free,
  output logic                          push,
  output drr_pkg::result_t              push_data,
  output logic                          wr_en,
  output logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  output drr_pkg::entry_t               wr_data,
  output logic                          rd_en,
  output logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  input  drr_pkg::entry_t               rd_data
);
  import drr_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int SUM_W  = CNT_W + SIZE_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  // Control state.
  seq_state_t             state, state_next;
  logic [SLOT_COUNT-1:0]  busy, busy_next;
  logic [CNT_W-1:0]       pend_cnt, pend_cnt_next;
  logic [SLOT_W-1:0]      cursor, cursor_next;
  logic                   hold_valid, hold_valid_next;

  // Working registers of the current item.
  item_t                  cur, cur_next;
  logic [SLOT_W-1:0]      scan, scan_next;
  logic [SLOT_W-1:0]      steps, steps_next;
  logic [SUM_W-1:0]       total, total_next;
  result_t                hold, hold_next;

  // Combinational helpers.
  logic [SLOT_W-1:0]      scan_inc;
  logic [SLOT_W-1:0]      cursor_inc;
  logic                   qidx_ok;
  logic                   pending;
  logic [SUM_W-1:0]       sum;
  logic                   over_budget;
  logic                   rd_is_fill;
  result_t                stop_hold;
  result_t                desc;

  assign idle = (state == ST_IDLE);

  // Step and add unit.
  always_comb begin
    scan_inc    = (scan == LAST_SLOT) ? '0 : scan + SLOT_W'(1);
    cursor_inc  = (cursor == LAST_SLOT) ? '0 : cursor + SLOT_W'(1);
    sum         = total + SUM_W'(rd_data.size);
    over_budget = BUDGET_W'(sum) > cfg.budget;
  end

  // Wait query answer, taken straight from the incoming beat.
  always_comb begin
    qidx_ok = ({1'b0, item.query_index} < (SLOT_NUM_W + 1)'(SLOT_COUNT));
    if (item.query_all) begin
      pending = (pend_cnt != '0);
    end else begin
      pending = qidx_ok && busy[item.query_index[SLOT_W-1:0]];
    end
  end

  // Descriptor formed from the slot just read, and the result that ends a pass.
  always_comb begin
    rd_is_fill = (rd_data.mode == MODE_FILL16) || (rd_data.mode == MODE_FILL32);
    desc       = '0;
    desc.kind  = KIND_DESC;
    desc.slot  = SLOT_NUM_W'(cursor);
    desc.mode  = rd_data.mode;
    desc.src   = rd_is_fill ? '0 : rd_data.data;
    desc.dest  = rd_data.dest;
    desc.size  = rd_data.size;
    desc.value = rd_is_fill ? rd_data.data : '0;
    desc.last  = 1'b0;
    if (hold_valid) begin
      stop_hold      = hold;
      stop_hold.last = 1'b1;
    end else begin
      stop_hold = make_reply(KIND_PASS_IDLE, '0);
    end
  end

  // Slot write data from the latched enqueue beat.
  always_comb begin
    wr_data      = '0;
    wr_data.dest = cur.dest_addr;
    wr_data.size = cur.byte_count;
    if (cur.req_type == REQ_FILL) begin
      wr_data.mode = cur.wide_units ? MODE_FILL32 : MODE_FILL16;
      wr_data.data = cur.wide_units ? cur.fill_word : {16'b0, cur.fill_word[15:0]};
    end else begin
      wr_data.mode = cur.wide_units ? MODE_COPY32 : MODE_COPY16;
      wr_data.data = cur.src_addr;
    end
  end

  // Next state and strobes.
  always_comb begin
    state_next      = state;
    busy_next       = busy;
    pend_cnt_next   = pend_cnt;
    cursor_next     = cursor;
    hold_valid_next = hold_valid;
    cur_next        = cur;
    scan_next       = scan;
    steps_next      = steps;
    total_next      = total;
    hold_next       = hold;
    push            = 1'b0;
    push_data       = hold;
    wr_en           = 1'b0;
    wr_addr         = scan;
    rd_en           = 1'b0;
    rd_addr         = cursor;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cur_next = item;
          unique case (item.req_type)
            REQ_COPY, REQ_FILL: begin
              scan_next  = cursor;
              steps_next = '0;
              state_next = ST_FIND;
            end
            REQ_PROCESS: begin
              total_next      = '0;
              hold_valid_next = 1'b0;
              state_next      = ST_WALK;
            end
            REQ_WAIT: begin
              hold_next  = make_reply(pending ? KIND_PENDING : KIND_DONE,
                                      item.query_all ? '0 : item.query_index);
              state_next = ST_REPLY;
            end
            REQ_CLEAR: begin
              busy_next     = '0;
              pend_cnt_next = '0;
              cursor_next   = '0;
              hold_next     = make_reply(KIND_CLEARED, '0);
              state_next    = ST_REPLY;
            end
            default: begin
            end
          endcase
        end
      end

      // One slot of the free search per cycle.
      ST_FIND: begin
        if (!busy[scan]) begin
          wr_en = 1'b1;
          if (cur.byte_count != '0) begin
            busy_next[scan] = 1'b1;
            pend_cnt_next   = pend_cnt + CNT_W'(1);
          end
          hold_next  = make_reply(KIND_GRANT, SLOT_NUM_W'(scan));
          state_next = ST_REPLY;
        end else if (steps == LAST_SLOT) begin
          hold_next  = make_reply(KIND_FULL, '0);
          state_next = ST_REPLY;
        end else begin
          scan_next  = scan_inc;
          steps_next = steps + SLOT_W'(1);
        end
      end

      // Check the slot under the cursor and read it if the pass goes on.
      ST_WALK: begin
        if (!busy[cursor] || (cur.line_count > cfg.last_line)) begin
          hold_next  = stop_hold;
          state_next = ST_REPLY;
        end else begin
          rd_en      = 1'b1;
          state_next = ST_DECIDE;
        end
      end

      // Budget check; the held descriptor goes out once the next one is taken.
      ST_DECIDE: begin
        if (over_budget) begin
          hold_next  = stop_hold;
          state_next = ST_REPLY;
        end else if (!hold_valid || out_free) begin
          push              = hold_valid;
          hold_next         = desc;
          hold_valid_next   = 1'b1;
          total_next        = sum;
          busy_next[cursor] = 1'b0;
          pend_cnt_next     = pend_cnt - CNT_W'(1);
          cursor_next       = cursor_inc;
          state_next        = ST_WALK;
        end
      end

      // Final result of the item.
      ST_REPLY: begin
        if (out_free) begin
          push       = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      busy       <= '0;
      pend_cnt   <= '0;
      cursor     <= '0;
      hold_valid <= 1'b0;
    end else begin
      state      <= state_next;
      busy       <= busy_next;
      pend_cnt   <= pend_cnt_next;
      cursor     <= cursor_next;
      hold_valid <= hold_valid_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cur   <= cur_next;
    scan  <= scan_next;
    steps <= steps_next;
    total <= total_next;
    hold  <= hold_next;
  end

endmodule
